// ----- hw/rtl/erm_pkg.sv -----
// shared constants and functions of the euler rotation matrix core
package erm_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN = 30;

  // angle format q8.24, 34 bits covers modulo work
  localparam int AW = 34;
  localparam logic signed [AW-1:0] PI_Q = 34'sd52707179;
  localparam logic signed [AW-1:0] TWO_PI_Q = 34'sd105414358;
  localparam logic signed [AW-1:0] HALF_PI_Q = 34'sd26353589;

  // cordic x/y format q2.30 with headroom
  localparam int XW = 34;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  // arctangent of 2^-i in q8.24
  function automatic logic signed [AW-1:0] atan_q24(input int i);
    logic signed [AW-1:0] r;
    begin
      case (i)
        0: r = 34'sd13176795;
        1: r = 34'sd7778716;
        2: r = 34'sd4110060;
        3: r = 34'sd2086331;
        4: r = 34'sd1047214;
        5: r = 34'sd524117;
        6: r = 34'sd262123;
        7: r = 34'sd131069;
        default: r = (i < 25) ? AW'(34'sd1 <<< (24 - i)) : '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hw/rtl/erm_sincos.sv -----
// pipelined angle reduction and cordic sine/cosine for one angle
module erm_sincos #(
  parameter int CORDIC_STEPS = erm_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] factor,
  input  logic signed [15:0] amount,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);
  localparam int AW = erm_pkg::AW;
  localparam int XW = erm_pkg::XW;
  localparam int QB = 6; // quotient bits of product / 2pi

  // stage 0: product
  logic signed [31:0] prod;
  always_ff @(posedge clk) begin
    if (en) prod <= factor * amount;
  end

  // stage 1: quotient estimate by reciprocal, q in about -11..10
  // 1/(2pi) scaled by 2^40: 2^40/105414358 = 10430.378
  logic signed [AW-1:0] prod_e;
  logic signed [47:0] qmul;
  logic signed [QB-1:0] qest;
  logic signed [AW-1:0] prod1;
  assign prod_e = AW'(prod);
  assign qmul = 48'(prod) * 48'sd10430;
  always_ff @(posedge clk) begin
    if (en) begin
      qest  <= QB'(qmul >>> 40);
      prod1 <= prod_e;
    end
  end

  // stage 2: remainder candidate
  logic signed [AW+QB-1:0] qprod;
  logic signed [AW-1:0] rem2;
  assign qprod = (AW+QB)'(qest) * (AW+QB)'(erm_pkg::TWO_PI_Q);
  always_ff @(posedge clk) begin
    if (en) rem2 <= prod1 - AW'(qprod);
  end

  // stage 3: correct into [0,2pi), center, fold
  logic signed [AW-1:0] r_a, r_b, r_c;
  logic fold;
  logic signed [AW-1:0] z0;
  logic neg0;
  always_comb begin
    r_a = rem2;
    if (r_a < 0) r_a = r_a + erm_pkg::TWO_PI_Q;
    if (r_a >= erm_pkg::TWO_PI_Q) r_a = r_a - erm_pkg::TWO_PI_Q;
    r_b = (r_a >= erm_pkg::PI_Q) ? r_a - erm_pkg::TWO_PI_Q : r_a;
    fold = 1'b0;
    r_c = r_b;
    if (r_b > erm_pkg::HALF_PI_Q) begin
      r_c = r_b - erm_pkg::PI_Q;
      fold = 1'b1;
    end else if (r_b < -erm_pkg::HALF_PI_Q) begin
      r_c = r_b + erm_pkg::PI_Q;
      fold = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z0   <= r_c;
      neg0 <= fold;
    end
  end

  // cordic stages, one rotation per register stage
  logic signed [XW-1:0] xs [0:CORDIC_STEPS];
  logic signed [XW-1:0] ys [0:CORDIC_STEPS];
  logic signed [AW-1:0] zs [0:CORDIC_STEPS];
  logic                 ns [0:CORDIC_STEPS];
  assign xs[0] = erm_pkg::GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = z0;
  assign ns[0] = neg0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xn, yn;
    logic signed [AW-1:0] zn;
    always_comb begin
      if (zs[i] >= 0) begin
        xn = xs[i] - (ys[i] >>> i);
        yn = ys[i] + (xs[i] >>> i);
        zn = zs[i] - erm_pkg::atan_q24(i);
      end else begin
        xn = xs[i] + (ys[i] >>> i);
        yn = ys[i] - (xs[i] >>> i);
        zn = zs[i] + erm_pkg::atan_q24(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= xn;
        ys[i+1] <= yn;
        zs[i+1] <= zn;
        ns[i+1] <= ns[i];
      end
    end
  end

  // round q2.30 to q2.14 and apply fold sign
  logic signed [XW-1:0] xr, yr;
  logic signed [15:0] cr, sr;
  assign xr = (xs[CORDIC_STEPS] + XW'(32768)) >>> 16;
  assign yr = (ys[CORDIC_STEPS] + XW'(32768)) >>> 16;
  assign cr = 16'(xr);
  assign sr = 16'(yr);
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= ns[CORDIC_STEPS] ? -cr : cr;
      sin_q <= ns[CORDIC_STEPS] ? -sr : sr;
    end
  end
endmodule

// ----- hw/rtl/erm_matrix.sv -----
// pipelined matrix entry products, rounding and saturation
module erm_matrix (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] sp, cp, st, ct, sr, cr,
  output logic signed [15:0] m [0:8]
);
  // stage a: pair products, q4.28
  logic signed [31:0] ctcr, cpsr, spst, spsr, cpst, ctsr, cpcr, spcr, spct, cpct;
  logic signed [15:0] cr_a, sr_a, st_a;
  always_ff @(posedge clk) begin
    if (en) begin
      ctcr <= ct * cr;  cpsr <= cp * sr;  spst <= sp * st;
      spsr <= sp * sr;  cpst <= cp * st;  ctsr <= ct * sr;
      cpcr <= cp * cr;  spcr <= sp * cr;  spct <= sp * ct;
      cpct <= cp * ct;
      cr_a <= cr;  sr_a <= sr;  st_a <= st;
    end
  end

  // stage b: three-factor products, q.42
  logic signed [47:0] t_spstcr, t_cpstcr, t_spstsr, t_cpstsr;
  logic signed [47:0] e [0:8];
  always_ff @(posedge clk) begin
    if (en) begin
      t_spstcr <= spst * cr_a;
      t_cpstcr <= cpst * cr_a;
      t_spstsr <= spst * sr_a;
      t_cpstsr <= cpst * sr_a;
      e[0] <= 48'(ctcr) <<< 14;
      e[1] <= -(48'(cpsr) <<< 14);
      e[2] <= 48'(spsr) <<< 14;
      e[3] <= 48'(ctsr) <<< 14;
      e[4] <= 48'(cpcr) <<< 14;
      e[5] <= -(48'(spcr) <<< 14);
      e[6] <= -(48'(st_a) <<< 28);
      e[7] <= 48'(spct) <<< 14;
      e[8] <= 48'(cpct) <<< 14;
    end
  end

  // stage c: sums
  logic signed [47:0] s [0:8];
  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= e[0];
      s[1] <= e[1] + t_spstcr;
      s[2] <= e[2] + t_cpstcr;
      s[3] <= e[3];
      s[4] <= e[4] + t_spstsr;
      s[5] <= e[5] + t_cpstsr;
      s[6] <= e[6];
      s[7] <= e[7];
      s[8] <= e[8];
    end
  end

  // stage d: round and saturate
  for (genvar k = 0; k < 9; k++) begin : g_sat
    logic signed [47:0] v;
    assign v = (s[k] + 48'sd134217728) >>> 28;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v > 48'sd32767) m[k] <= 16'sh7fff;
        else if (v < -48'sd32768) m[k] <= 16'sh8000;
        else m[k] <= 16'(v);
      end
    end
  end
endmodule

// ----- hw/rtl/euler_rotation_matrix_core.sv -----
// top level: euler angles to 4x4 zyx rotation matrix, one row per output word
//
// channel  | signals                               | direction
// in       | in_valid/in_ready, axis_*, amount     | input word
// out      | out_valid/out_ready, row_index, col*  | four words per input
//
// the pipeline is 4 + CORDIC_STEPS + 1 + 4 stages deep and advances when its
// last stage is free or being drained. the row serializer emits four words,
// so a full pipeline takes an input only as the last word goes out. reset
// clears vld, hold, row; a stall halts the pipeline when its tail is valid.
module euler_rotation_matrix_core #(
  parameter int CORDIC_STEPS = erm_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row_index,
  output logic signed [15:0] col0,
  output logic signed [15:0] col1,
  output logic signed [15:0] col2,
  output logic signed [15:0] col3,
  output logic               last_row
);
  localparam int DEPTH = 4 + CORDIC_STEPS + 1 + 4;

  // serializer holds one matrix while its rows go out
  logic             hold;
  logic [1:0]       row;
  logic signed [15:0] mat [0:8];
  logic             done;
  assign done = hold && out_ready && (row == 2'd3);

  // pipeline moves when its tail is empty or the serializer takes it
  logic [DEPTH-1:0] vld;
  logic             en;
  logic             load;
  assign load = vld[DEPTH-1] && (!hold || done);
  assign en = !vld[DEPTH-1] || load;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  logic signed [15:0] sp, cp, st, ct, sr, cr;
  logic signed [15:0] m [0:8];
  erm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .factor(axis_x), .amount(amount), .sin_q(sp), .cos_q(cp));
  erm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .factor(axis_y), .amount(amount), .sin_q(st), .cos_q(ct));
  erm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .factor(axis_z), .amount(amount), .sin_q(sr), .cos_q(cr));
  erm_matrix u_mat (
    .clk(clk), .en(en), .sp(sp), .cp(cp), .st(st), .ct(ct), .sr(sr), .cr(cr), .m(m));

  // row serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
      row  <= 2'd0;
    end else if (load) begin
      hold <= 1'b1;
      row  <= 2'd0;
    end else if (hold && out_ready) begin
      if (row == 2'd3) hold <= 1'b0;
      row <= row + 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (load) mat <= m;
  end

  // output word
  always_comb begin
    out_valid = hold;
    row_index = row;
    last_row  = (row == 2'd3);
    col3      = '0;
    case (row)
      2'd0: begin col0 = mat[0]; col1 = mat[1]; col2 = mat[2]; end
      2'd1: begin col0 = mat[3]; col1 = mat[4]; col2 = mat[5]; end
      2'd2: begin col0 = mat[6]; col1 = mat[7]; col2 = mat[8]; end
      default: begin
        col0 = '0; col1 = '0; col2 = '0; col3 = 16'sd16384;
      end
    endcase
  end

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!hold || done)) else $error("matrix overwritten");
  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    (hold && out_ready && row != 2'd3 && !load) |=> (hold && row == $past(row) + 2'd1))
    else $error("row did not advance");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1] && hold && !done) |-> !en) else $error("pipeline moved under stall");
endmodule
